>>> sv/mqtt_incoming_packet_parser_core_macros.svh
// Assertion helpers for the packet parser checks.
`ifndef MQTT_INCOMING_PACKET_PARSER_CORE_MACROS_SVH
`define MQTT_INCOMING_PACKET_PARSER_CORE_MACROS_SVH

// Checked out of reset only.
`define MQTTP_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define MQTTP_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> sv/mqttp_pkg.sv
package mqttp_pkg;

    localparam int MAX_VARINT_BYTES = 4;
    localparam int VARINT_BITS      = 7;
    localparam int RT_W             = VARINT_BITS * MAX_VARINT_BYTES;
    localparam int SH_W             = (RT_W > 1) ? $clog2(RT_W) : 1;
    localparam int VC_W             = $clog2(MAX_VARINT_BYTES + 1);

    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] TYPE_CONNACK  = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_SUBACK   = 4'd9;
    localparam logic [3:0] TYPE_UNSUBACK = 4'd11;
    localparam logic [3:0] TYPE_PINGRESP = 4'd13;

    localparam logic [1:0] SEC_TOPIC   = 2'd0;
    localparam logic [1:0] SEC_MESSAGE = 2'd1;
    localparam logic [1:0] SEC_SUBACK  = 2'd2;
    localparam logic [1:0] SEC_SUMMARY = 2'd3;

    localparam logic [2:0] EV_CONNACK  = 3'd0;
    localparam logic [2:0] EV_PUBLISH  = 3'd1;
    localparam logic [2:0] EV_PUBACK   = 3'd2;
    localparam logic [2:0] EV_SUBACK   = 3'd3;
    localparam logic [2:0] EV_UNSUBACK = 3'd4;
    localparam logic [2:0] EV_PINGRESP = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;

    localparam logic [1:0] QOS_INVALID = 2'd3;

    typedef enum logic [3:0] {
        PH_HDR      = 4'd0,
        PH_LEN      = 4'd1,
        PH_CONNACK  = 4'd2,
        PH_TLH      = 4'd3,
        PH_TLL      = 4'd4,
        PH_TOPIC    = 4'd5,
        PH_IDH      = 4'd6,
        PH_IDL      = 4'd7,
        PH_MLH      = 4'd8,
        PH_MLL      = 4'd9,
        PH_MSG      = 4'd10,
        PH_PUBDONE  = 4'd11,
        PH_SUBID    = 4'd12,
        PH_SUBCODES = 4'd13,
        PH_IGNORE   = 4'd14,
        PH_DISCARD  = 4'd15
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  section;
        logic [7:0]  data_byte;
        logic [2:0]  event_res;
        logic        dup_flag;
        logic        retain_flag;
        logic [1:0]  qos_level;
        logic        session_present;
        logic [7:0]  connack_code;
        logic [15:0] packet_ident;
        logic [15:0] topic_length;
        logic [15:0] body_length;
        logic        reply_needed;
    } result_item_t;

    typedef struct packed {
        logic [1:0]   count;
        result_item_t first;
        result_item_t second;
    } push_t;

endpackage

>>> sv/mqttp_front.sv
module mqttp_front
    import mqttp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  byte_item_t byte_item,
    output push_t      push
);

    phase_t          phase_reg, phase_next, phase_upd;
    logic [3:0]      type_reg, type_next, type_upd;
    logic [3:0]      flags_reg, flags_next, flags_upd;
    logic [RT_W-1:0] rt_reg, rt_next, rt_upd;
    logic [VC_W-1:0] vc_reg, vc_next, vc_upd;
    logic [RT_W-1:0] bl_reg, bl_next, bl_upd;
    logic [15:0]     fc_reg, fc_next, fc_upd;
    logic [15:0]     tl_reg, tl_next, tl_upd;
    logic [15:0]     bd_reg, bd_next, bd_upd;
    logic [15:0]     id_reg, id_next, id_upd;
    logic [8:0]      ack_reg, ack_next, ack_upd;
    logic            emit;
    logic [1:0]      emit_sec;

    function automatic phase_t after_topic(logic qos_nz, logic [RT_W-1:0] left);
        phase_t p;
        if (qos_nz)
        begin
            p = (32'(left) < 32'd2) ? PH_DISCARD : PH_IDH;
        end
        else
        begin
            p = (left != '0) ? PH_MLH : PH_PUBDONE;
        end
        return p;
    endfunction

    always_comb
    begin
        logic [7:0]      b;
        logic [RT_W-1:0] bl_dec;
        logic [RT_W-1:0] rt_sum;
        logic [RT_W-1:0] cnt;
        logic [VC_W-1:0] vc_inc;
        logic [SH_W-1:0] sh;
        logic [16:0]     fc_inc;
        logic [15:0]     full;
        logic            qos_nz;

        b        = byte_item.in_byte;
        bl_dec   = bl_reg - RT_W'(1);
        sh       = SH_W'(vc_reg) * SH_W'(VARINT_BITS);
        rt_sum   = rt_reg + (RT_W'(b[6:0]) << sh);
        vc_inc   = vc_reg + VC_W'(1);
        cnt      = rt_reg - RT_W'(2);
        fc_inc   = 17'(fc_reg) + 17'd1;
        qos_nz   = (flags_reg[2:1] != 2'd0);
        full     = 16'h0000;

        phase_upd = phase_reg;
        type_upd  = type_reg;
        flags_upd = flags_reg;
        rt_upd    = rt_reg;
        vc_upd    = vc_reg;
        bl_upd    = bl_reg;
        fc_upd    = fc_reg;
        tl_upd    = tl_reg;
        bd_upd    = bd_reg;
        id_upd    = id_reg;
        ack_upd   = ack_reg;
        emit      = 1'b0;
        emit_sec  = SEC_TOPIC;

        if (accept)
        begin
            if (phase_reg == PH_HDR)
            begin
                type_upd  = b[7:4];
                flags_upd = b[3:0];
                phase_upd = PH_LEN;
                unique case (b[7:4]) inside
                    TYPE_CONNACK, TYPE_PUBACK, TYPE_SUBACK, TYPE_UNSUBACK, TYPE_PINGRESP:
                    begin
                    end
                    TYPE_PUBLISH:
                    begin
                        if (b[2:1] == QOS_INVALID)
                        begin
                            phase_upd = PH_DISCARD;
                        end
                    end
                    default:
                    begin
                        phase_upd = PH_DISCARD;
                    end
                endcase
            end
            else if (phase_reg == PH_LEN)
            begin
                rt_upd = rt_sum;
                vc_upd = vc_inc;
                if (b[7])
                begin
                    if (32'(vc_inc) >= 32'(MAX_VARINT_BYTES))
                    begin
                        phase_upd = PH_DISCARD;
                    end
                end
                else
                begin
                    bl_upd = rt_sum;
                    unique case (type_reg) inside
                        TYPE_CONNACK:
                        begin
                            fc_upd    = 16'd0;
                            phase_upd = PH_CONNACK;
                        end
                        TYPE_PUBLISH:
                        begin
                            phase_upd = PH_TLH;
                        end
                        TYPE_SUBACK:
                        begin
                            if (32'(rt_sum) < 32'd3)
                            begin
                                phase_upd = PH_DISCARD;
                            end
                            else
                            begin
                                fc_upd    = 16'd0;
                                phase_upd = PH_SUBID;
                            end
                        end
                        default:
                        begin
                            phase_upd = PH_IGNORE;
                        end
                    endcase
                end
            end
            else if (phase_reg != PH_DISCARD)
            begin
                if (bl_reg == '0)
                begin
                    phase_upd = PH_DISCARD;
                end
                else
                begin
                    bl_upd = bl_dec;
                    unique case (phase_reg)
                        PH_CONNACK:
                        begin
                            if (fc_reg == 16'd0)
                            begin
                                ack_upd[0] = b[0];
                            end
                            else if (fc_reg == 16'd1)
                            begin
                                ack_upd[8:1] = b;
                            end
                            if (fc_reg < 16'd2)
                            begin
                                fc_upd = fc_inc[15:0];
                            end
                        end
                        PH_TLH:
                        begin
                            tl_upd    = {b, 8'h00};
                            phase_upd = PH_TLL;
                        end
                        PH_TLL:
                        begin
                            full   = {tl_reg[15:8], b};
                            tl_upd = full;
                            if (32'(full) > 32'(bl_dec))
                            begin
                                phase_upd = PH_DISCARD;
                            end
                            else
                            begin
                                fc_upd    = 16'd0;
                                phase_upd = (full == 16'd0) ? after_topic(qos_nz, bl_dec)
                                                            : PH_TOPIC;
                            end
                        end
                        PH_TOPIC:
                        begin
                            emit     = 1'b1;
                            emit_sec = SEC_TOPIC;
                            fc_upd   = fc_inc[15:0];
                            if (fc_inc >= 17'(tl_reg))
                            begin
                                phase_upd = after_topic(qos_nz, bl_dec);
                            end
                        end
                        PH_IDH:
                        begin
                            id_upd    = {b, 8'h00};
                            phase_upd = PH_IDL;
                        end
                        PH_IDL:
                        begin
                            id_upd    = {id_reg[15:8], b};
                            phase_upd = (bl_dec != '0) ? PH_MLH : PH_PUBDONE;
                        end
                        PH_MLH:
                        begin
                            bd_upd    = {b, 8'h00};
                            phase_upd = PH_MLL;
                        end
                        PH_MLL:
                        begin
                            full   = {bd_reg[15:8], b};
                            bd_upd = full;
                            if (32'(full) > 32'(bl_dec))
                            begin
                                phase_upd = PH_DISCARD;
                            end
                            else if (full == 16'd0)
                            begin
                                phase_upd = (bl_dec != '0) ? PH_DISCARD : PH_PUBDONE;
                            end
                            else
                            begin
                                fc_upd    = 16'd0;
                                phase_upd = PH_MSG;
                            end
                        end
                        PH_MSG:
                        begin
                            emit     = 1'b1;
                            emit_sec = SEC_MESSAGE;
                            fc_upd   = fc_inc[15:0];
                            if (fc_inc >= 17'(bd_reg))
                            begin
                                phase_upd = (bl_dec != '0) ? PH_DISCARD : PH_PUBDONE;
                            end
                        end
                        PH_SUBID:
                        begin
                            fc_upd = fc_inc[15:0];
                            if (fc_inc >= 17'd2)
                            begin
                                bd_upd    = (32'(cnt) > 32'h0000_FFFF) ? 16'hFFFF
                                                                      : 16'(cnt);
                                phase_upd = PH_SUBCODES;
                            end
                        end
                        PH_SUBCODES:
                        begin
                            emit     = 1'b1;
                            emit_sec = SEC_SUBACK;
                        end
                        PH_IGNORE:
                        begin
                        end
                        default:
                        begin
                            phase_upd = PH_DISCARD;
                        end
                    endcase
                end
            end
        end

        if (accept && byte_item.last)
        begin
            phase_next = PH_HDR;
            type_next  = 4'd0;
            flags_next = 4'd0;
            rt_next    = '0;
            vc_next    = '0;
            bl_next    = '0;
            fc_next    = 16'd0;
            tl_next    = 16'd0;
            bd_next    = 16'd0;
            id_next    = 16'd0;
            ack_next   = 9'd0;
        end
        else
        begin
            phase_next = phase_upd;
            type_next  = type_upd;
            flags_next = flags_upd;
            rt_next    = rt_upd;
            vc_next    = vc_upd;
            bl_next    = bl_upd;
            fc_next    = fc_upd;
            tl_next    = tl_upd;
            bd_next    = bd_upd;
            id_next    = id_upd;
            ack_next   = ack_upd;
        end
    end

    always_comb
    begin
        result_item_t data_res;
        result_item_t sum_res;
        logic         ok;

        data_res           = '0;
        data_res.section   = emit_sec;
        data_res.data_byte = byte_item.in_byte;

        ok = (phase_upd != PH_HDR) && (phase_upd != PH_LEN) && (phase_upd != PH_DISCARD)
             && (bl_upd == '0)
             && !((type_upd == TYPE_PUBLISH) && (phase_upd != PH_PUBDONE));

        sum_res         = '0;
        sum_res.section = SEC_SUMMARY;
        if (!ok)
        begin
            sum_res.event_res = EV_ERROR;
        end
        else
        begin
            unique case (type_upd) inside
                TYPE_CONNACK:
                begin
                    sum_res.event_res       = EV_CONNACK;
                    sum_res.session_present = ack_upd[0];
                    sum_res.connack_code    = ack_upd[8:1];
                end
                TYPE_PUBLISH:
                begin
                    sum_res.event_res    = EV_PUBLISH;
                    sum_res.dup_flag     = flags_upd[3];
                    sum_res.retain_flag  = flags_upd[0];
                    sum_res.qos_level    = flags_upd[2:1];
                    sum_res.packet_ident = id_upd;
                    sum_res.topic_length = tl_upd;
                    sum_res.body_length  = bd_upd;
                    sum_res.reply_needed = (flags_upd[2:1] != 2'd0);
                end
                TYPE_PUBACK:
                begin
                    sum_res.event_res = EV_PUBACK;
                end
                TYPE_SUBACK:
                begin
                    sum_res.event_res   = EV_SUBACK;
                    sum_res.body_length = bd_upd;
                end
                TYPE_UNSUBACK:
                begin
                    sum_res.event_res = EV_UNSUBACK;
                end
                default:
                begin
                    sum_res.event_res = EV_PINGRESP;
                end
            endcase
        end

        push.count  = 2'd0;
        push.first  = data_res;
        push.second = sum_res;
        if (accept)
        begin
            if (emit && byte_item.last)
            begin
                push.count = 2'd2;
            end
            else if (emit)
            begin
                push.count = 2'd1;
            end
            else if (byte_item.last)
            begin
                push.count = 2'd1;
                push.first = sum_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            type_reg  <= 4'd0;
            flags_reg <= 4'd0;
            rt_reg    <= '0;
            vc_reg    <= '0;
            bl_reg    <= '0;
            fc_reg    <= 16'd0;
            tl_reg    <= 16'd0;
            bd_reg    <= 16'd0;
            id_reg    <= 16'd0;
            ack_reg   <= 9'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            flags_reg <= flags_next;
            rt_reg    <= rt_next;
            vc_reg    <= vc_next;
            bl_reg    <= bl_next;
            fc_reg    <= fc_next;
            tl_reg    <= tl_next;
            bd_reg    <= bd_next;
            id_reg    <= id_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

>>> sv/mqttp_queue.sv
module mqttp_queue
    import mqttp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  push_t        push,
    output logic         push_block,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    result_item_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    // keep room for a data byte plus its summary
    assign push_block   = (32'(count_reg) > 32'(QUEUE_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result_item  = mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/mqtt_incoming_packet_parser_core.sv
// A result transaction is queued when its byte is accepted and offered after earlier ones.
// One byte is accepted per cycle unless byte_stall is high (more than two entries queued);
// the result port drains one transaction per cycle while result_stall is low from a
// four-entry queue, and a data byte that ends its packet pushes data plus summary.
// Reset: rst_n asynchronously clears the parser to header-expected and empties the queue.
module mqtt_incoming_packet_parser_core
    import mqttp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    push_t push;
    logic  accept;

    assign accept = byte_valid && !byte_stall;

    mqttp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_item (byte_item),
        .push      (push)
    );

    mqttp_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_block   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

>>> sv/mqttp_checker.sv
`include "mqtt_incoming_packet_parser_core_macros.svh"

module mqttp_checker
    import mqttp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         byte_valid,
    input logic         byte_stall,
    input byte_item_t   byte_item,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    logic in_last;
    logic data_out;
    logic data_clear;
    logic error_out;
    logic error_clear;

    assign in_last     = byte_valid && !byte_stall && byte_item.last;
    assign data_out    = result_valid && (result_item.section != SEC_SUMMARY);
    assign data_clear  = (result_item.event_res == EV_CONNACK)
                         && (result_item.packet_ident == 16'd0)
                         && (result_item.body_length == 16'd0)
                         && !result_item.reply_needed;
    assign error_out   = result_valid && (result_item.section == SEC_SUMMARY)
                         && (result_item.event_res == EV_ERROR);
    assign error_clear = (result_item.data_byte == 8'd0)
                         && (result_item.topic_length == 16'd0)
                         && (result_item.connack_code == 8'd0)
                         && !result_item.reply_needed;

    `MQTTP_CHECK_ALWAYS(a_idle_in_reset, !rst_n |=> !result_valid, "result offered in reset")

    `MQTTP_CHECK(a_summary_follows_last, in_last |=> result_valid, "no summary after last byte")

    `MQTTP_CHECK(a_data_fields_clear, data_out |-> data_clear, "data carries summary fields")

    `MQTTP_CHECK(a_error_fields_clear, error_out |-> error_clear, "error summary carries fields")

    `MQTTP_CHECK(a_result_holds, (result_valid && result_stall) |=> (result_valid && $stable(result_item)), "stalled result changed")

endmodule

bind mqtt_incoming_packet_parser_core mqttp_checker u_checker (.*);
